/* hdl/mrlb_pkg.sv */
package mrlb_pkg;
    localparam int BUF_BYTES = 4096;
    localparam int IDX_W = $clog2(BUF_BYTES);
    localparam int FREE_W = IDX_W + 1;
    localparam logic [FREE_W-1:0] BUF_SIZE = FREE_W'(BUF_BYTES);

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_OPEN  = 2'd2;
    localparam logic [1:0] REQ_FETCH = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_BYTE   = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture request fields
        OP_RD_LEN_LO,  // read address read_index+4
        OP_RD_LEN_HI,  // read address read_index+5
        OP_DROP,       // drop head message using length in register
        OP_PUT_HDR,    // write header byte hdr_cnt
        OP_PUT_DATA,   // write payload byte
        OP_SKIP_DATA,  // count rejected byte
        OP_REJECT,
        OP_OPEN,
        OP_RD_BYTE,    // read byte at read_index
        OP_FETCH_GO,   // advance drain by one byte
        OP_FETCH_FIN,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       start_frame;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       pending;
        logic       drain_open;
        logic       too_big;
        logic       need_drop;
        logic       hdr_last;
        logic       frame_zero;
        logic       empty;
        logic       over_budget;
    } stat_t;
endpackage

/* hdl/mrlb_datapath.sv */
module mrlb_datapath
    import mrlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  in_req,
    input  logic [15:0] in_len,
    input  logic [31:0] in_stamp,
    input  logic [7:0]  in_byte,
    input  logic [15:0] in_limit,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        disc,
    output logic [7:0]  res_byte,
    output logic [15:0] res_total
);
    logic [IDX_W-1:0]  wr_idx_reg, rd_idx_reg;
    logic [FREE_W-1:0] free_reg;
    logic [15:0]       pend_reg, budget_reg, used_reg, frame_reg;
    logic              disc_reg, open_reg;
    logic [1:0]        req_reg;
    logic [15:0]       len_reg, limit_reg;
    logic [31:0]       stamp_reg;
    logic [7:0]        byte_reg;
    logic [2:0]        hdr_cnt_reg;
    logic [16:0]       hlen_reg;  // framed size of head message
    logic [7:0]        mem [BUF_BYTES];
    logic [7:0]        rdata_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [7:0]        wdata;
    logic [16:0]       framed;
    logic              hi_pend_reg;

    assign framed = 17'd6 + {1'b0, len_reg};

    // memory read address
    always_comb
    begin
        case (cmd.op)
            OP_RD_LEN_LO: rd_addr = rd_idx_reg + IDX_W'(4);
            OP_RD_LEN_HI: rd_addr = rd_idx_reg + IDX_W'(5);
            default:      rd_addr = rd_idx_reg;
        endcase
    end

    always_comb
    begin
        wr_en = (cmd.op == OP_PUT_HDR) || (cmd.op == OP_PUT_DATA);
        wr_addr = wr_idx_reg;
        case (hdr_cnt_reg)
            3'd0: wdata = stamp_reg[7:0];
            3'd1: wdata = stamp_reg[15:8];
            3'd2: wdata = stamp_reg[23:16];
            3'd3: wdata = stamp_reg[31:24];
            3'd4: wdata = len_reg[7:0];
            default: wdata = len_reg[15:8];
        endcase
        if (cmd.op == OP_PUT_DATA)
            wdata = byte_reg;
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wdata;
        rdata_reg <= mem[rd_addr];
    end

    // status to controller
    always_comb
    begin
        stat.req         = req_reg;
        stat.pending     = (pend_reg != 16'd0);
        stat.drain_open  = open_reg;
        stat.too_big     = (framed >= 17'(BUF_BYTES));
        stat.need_drop   = ({4'd0, free_reg} <= framed) && (free_reg < BUF_SIZE);
        stat.hdr_last    = (hdr_cnt_reg == 3'd5);
        stat.frame_zero  = (frame_reg == 16'd0);
        stat.empty       = (free_reg >= BUF_SIZE);
        stat.over_budget = ({1'b0, used_reg} + hlen_reg) >= {1'b0, budget_reg};
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            free_reg    <= BUF_SIZE;
            pend_reg    <= '0;
            disc_reg    <= 1'b0;
            budget_reg  <= '0;
            used_reg    <= '0;
            frame_reg   <= '0;
            open_reg    <= 1'b0;
            hdr_cnt_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_DROP:
                begin
                    rd_idx_reg <= rd_idx_reg + hlen_reg[IDX_W-1:0];
                    if ({4'd0, free_reg} + hlen_reg > 17'(BUF_BYTES))
                        free_reg <= BUF_SIZE;
                    else
                        free_reg <= free_reg + hlen_reg[FREE_W-1:0];
                end
                OP_PUT_HDR, OP_PUT_DATA:
                begin
                    wr_idx_reg <= wr_idx_reg + IDX_W'(1);
                    if (free_reg != '0)
                        free_reg <= free_reg - FREE_W'(1);
                    if (cmd.op == OP_PUT_HDR)
                    begin
                        hdr_cnt_reg <= (hdr_cnt_reg == 3'd5) ? 3'd0 : hdr_cnt_reg + 3'd1;
                        if (hdr_cnt_reg == 3'd5)
                        begin
                            pend_reg <= len_reg;
                            disc_reg <= 1'b0;
                        end
                    end
                    else
                        pend_reg <= pend_reg - 16'd1;
                end
                OP_SKIP_DATA:
                begin
                    pend_reg <= pend_reg - 16'd1;
                    if (pend_reg == 16'd1)
                        disc_reg <= 1'b0;
                end
                OP_REJECT:
                begin
                    pend_reg <= len_reg;
                    disc_reg <= (len_reg != 16'd0);
                end
                OP_OPEN:
                begin
                    budget_reg <= limit_reg;
                    used_reg   <= '0;
                    frame_reg  <= '0;
                    open_reg   <= 1'b1;
                end
                OP_FETCH_GO:
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (free_reg < BUF_SIZE)
                        free_reg <= free_reg + FREE_W'(1);
                    frame_reg <= (cmd.start_frame ? hlen_reg[15:0] : frame_reg) - 16'd1;
                    used_reg  <= used_reg + 16'd1;
                end
                OP_FETCH_FIN: open_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            req_reg   <= in_req;
            len_reg   <= in_len;
            stamp_reg <= in_stamp;
            byte_reg  <= in_byte;
            limit_reg <= in_limit;
        end
    end

    // second length byte arrives the cycle after its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hi_pend_reg <= 1'b0;
        else
            hi_pend_reg <= (cmd.op == OP_RD_LEN_HI);
    end

    // head message length: low byte first, then high byte plus header size
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RD_LEN_HI)
            hlen_reg <= {9'd0, rdata_reg};
        else if (hi_pend_reg)
            hlen_reg <= 17'd6 + {1'b0, rdata_reg, hlen_reg[7:0]};
    end

    // output byte capture
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FETCH_GO)
            res_byte <= rdata_reg;
        else if (cmd.out_load)
            res_byte <= 8'd0;
    end

    assign res_total = used_reg;
    assign disc      = disc_reg;
endmodule

/* hdl/mrlb_ctrl.sv */
module mrlb_ctrl
    import mrlb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    output logic       in_ready,
    input  logic       out_free,
    output logic       out_push,
    output logic [2:0] out_code,
    input  stat_t      stat,
    input  logic       disc,
    output cmd_t       cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_LEN_LO, S_LEN_HI, S_LEN_WAIT, S_LEN_USE,
        S_HDR, S_BYTE_RD, S_BYTE_GO, S_HOLD
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       fetch_reg, fetch_next;  // length read serves a fetch

    assign in_ready = (state_reg == S_IDLE);
    assign out_code = code_reg;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        fetch_next = fetch_reg;
        cmd        = '{op: OP_NONE, start_frame: 1'b0, out_load: 1'b0};
        out_push   = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd.op = OP_LATCH;
                    state_next = S_DEC;
                end
            S_DEC:
            begin
                state_next = S_HOLD;
                case (stat.req)
                    REQ_BEGIN:
                        if (stat.pending || stat.drain_open)
                            code_next = ST_ORDER;
                        else if (stat.too_big)
                        begin
                            cmd.op = OP_REJECT;
                            code_next = ST_REJECT;
                        end
                        else
                        begin
                            code_next = ST_OK;
                            fetch_next = 1'b0;
                            state_next = stat.need_drop ? S_LEN_LO : S_HDR;
                        end
                    REQ_DATA:
                        if (!stat.pending)
                            code_next = ST_ORDER;
                        else
                        begin
                            cmd.op = disc ? OP_SKIP_DATA : OP_PUT_DATA;
                            code_next = ST_OK;
                        end
                    REQ_OPEN:
                        if (stat.pending || stat.drain_open)
                            code_next = ST_ORDER;
                        else
                        begin
                            cmd.op = OP_OPEN;
                            code_next = ST_OK;
                        end
                    default:
                        if (!stat.drain_open)
                            code_next = ST_ORDER;
                        else if (!stat.frame_zero)
                        begin
                            code_next = ST_BYTE;
                            state_next = S_BYTE_RD;
                        end
                        else if (stat.empty)
                        begin
                            cmd.op = OP_FETCH_FIN;
                            code_next = ST_DONE;
                        end
                        else
                        begin
                            fetch_next = 1'b1;
                            state_next = S_LEN_LO;
                        end
                endcase
            end
            S_LEN_LO:
            begin
                cmd.op = OP_RD_LEN_LO;
                state_next = S_LEN_HI;
            end
            S_LEN_HI:
            begin
                cmd.op = OP_RD_LEN_HI;
                state_next = S_LEN_WAIT;
            end
            S_LEN_WAIT: state_next = S_LEN_USE;
            S_LEN_USE:
                if (!fetch_reg)
                begin
                    cmd.op = OP_DROP;
                    state_next = S_DEC;
                    // recheck drop condition next pass through decode
                end
                else if (stat.over_budget)
                begin
                    cmd.op = OP_FETCH_FIN;
                    code_next = ST_DONE;
                    state_next = S_HOLD;
                end
                else
                begin
                    code_next = ST_BYTE;
                    state_next = S_BYTE_RD;
                end
            S_HDR:
            begin
                cmd.op = OP_PUT_HDR;
                if (stat.hdr_last)
                    state_next = S_HOLD;
            end
            S_BYTE_RD: state_next = S_BYTE_GO;
            S_BYTE_GO:
            begin
                cmd.op = OP_FETCH_GO;
                cmd.start_frame = fetch_reg;
                fetch_next = 1'b0;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                cmd.out_load = (code_reg != ST_BYTE);
                if (out_free)
                begin
                    out_push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            fetch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            fetch_reg <= fetch_next;
        end
    end
endmodule

/* hdl/message_ring_log_buffer_unit.sv */
// Message ring log buffer.
// s_axis carries one request item: req_type, msg_len, stamp, data_byte,
// drain_limit packed in tdata. m_axis returns exactly one result item per
// request: out_byte, out_status, drained_total.
// Requests are handled one at a time by a controller sequencing a byte
// store with one write and one registered read port.
// Data, drain-open and refused requests go from decode straight to the
// output hold state; an accepted begin first drops old messages as needed
// and then writes the header; a fetch reads a byte from the store, at the
// start of a message after reading the header length from the store.
// tready is high only while no request is in work; the result sits in an
// output register, so a new request is taken the cycle after it is loaded.
// When m_axis stalls the next result waits, holding s_axis off.
// Reset empties the store (indices zero, free space full), closes any
// drain and clears pending payload; store contents stay undefined.
module message_ring_log_buffer_unit
    import mrlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[1:0], msg_len[17:2], stamp[49:18], data_byte[57:50],
    // drain_limit[73:58], zero fill to 80
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], out_status[10:8], drained_total[26:11], zero fill
    output logic [31:0] m_axis_tdata
);
    cmd_t        cmd;
    stat_t       stat;
    logic [7:0]  res_byte;
    logic [15:0] res_total;
    logic        out_push;
    logic [2:0]  code;
    logic        disc;
    logic        busy_reg;
    logic [26:0] out_reg;

    mrlb_datapath u_dp (
        .clk, .rst_n,
        .in_req   (s_axis_tdata[1:0]),
        .in_len   (s_axis_tdata[17:2]),
        .in_stamp (s_axis_tdata[49:18]),
        .in_byte  (s_axis_tdata[57:50]),
        .in_limit (s_axis_tdata[73:58]),
        .cmd, .stat, .disc, .res_byte, .res_total
    );

    mrlb_ctrl u_ctrl (
        .clk, .rst_n,
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .in_ready (s_axis_tready),
        .out_free (!busy_reg || m_axis_tready),
        .out_push, .out_code (code), .stat, .disc, .cmd
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (out_push)
            busy_reg <= 1'b1;
        else if (m_axis_tready)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            out_reg <= {res_total, code, (code == ST_BYTE) ? res_byte : 8'd0};
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {5'd0, out_reg};
endmodule

/* test/mrlb_checker.sv */
`timescale 1ns / 100ps

// Watches both streams, keeps a shadow copy of the log ring and compares
// every result item with the predicted one.
module mrlb_checker
    import mrlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          results_seen,
    output int          drops_seen,
    output int          rejects_seen
);
    typedef struct packed {
        logic [7:0]  obyte;
        logic [2:0]  status;
        logic [15:0] total;
    } result_t;

    logic [7:0]  ring [BUF_BYTES];
    int unsigned wr_idx;
    int unsigned rd_idx;
    int unsigned free_bytes;
    int unsigned payload_left;
    bit          skipping;
    int unsigned budget;
    int unsigned used;
    int unsigned frame_rem;
    bit          draining;
    result_t     expected_results[$];

    function automatic int unsigned head_size();
        return 6 + {ring[(rd_idx + 5) % BUF_BYTES], ring[(rd_idx + 4) % BUF_BYTES]};
    endfunction

    function automatic void store_byte(logic [7:0] v);
        ring[wr_idx] = v;
        wr_idx = (wr_idx + 1) % BUF_BYTES;
        if (free_bytes > 0)
            free_bytes--;
    endfunction

    // Work out the result of one accepted request and update the shadow state
    function automatic result_t log_predict(logic [79:0] d);
        logic [1:0]  req;
        logic [15:0] len;
        logic [31:0] stamp;
        logic [7:0]  dbyte;
        logic [15:0] limit;
        int unsigned framed;
        int unsigned sz;
        result_t     r;
        req   = d[1:0];
        len   = d[17:2];
        stamp = d[49:18];
        dbyte = d[57:50];
        limit = d[73:58];
        r.obyte  = '0;
        r.status = ST_OK;
        case (req)
            REQ_BEGIN:
            begin
                framed = 6 + len;
                if (payload_left != 0 || draining)
                    r.status = ST_ORDER;
                else if (framed >= BUF_BYTES)
                begin
                    r.status = ST_REJECT;
                    payload_left = len;
                    skipping = (len != 0);
                    rejects_seen++;
                end
                else
                begin
                    while (free_bytes <= framed && free_bytes < BUF_BYTES)
                    begin
                        sz = head_size();
                        rd_idx = (rd_idx + sz) % BUF_BYTES;
                        free_bytes += sz;
                        if (free_bytes > BUF_BYTES)
                            free_bytes = BUF_BYTES;
                        drops_seen++;
                    end
                    store_byte(stamp[7:0]);
                    store_byte(stamp[15:8]);
                    store_byte(stamp[23:16]);
                    store_byte(stamp[31:24]);
                    store_byte(len[7:0]);
                    store_byte(len[15:8]);
                    payload_left = len;
                    skipping = 0;
                end
            end
            REQ_DATA:
            begin
                if (payload_left == 0)
                    r.status = ST_ORDER;
                else
                begin
                    if (!skipping)
                        store_byte(dbyte);
                    payload_left--;
                    if (payload_left == 0)
                        skipping = 0;
                end
            end
            REQ_OPEN:
            begin
                if (payload_left != 0 || draining)
                    r.status = ST_ORDER;
                else
                begin
                    budget = limit;
                    used = 0;
                    frame_rem = 0;
                    draining = 1;
                end
            end
            default:
            begin
                if (!draining)
                    r.status = ST_ORDER;
                else
                begin
                    if (frame_rem == 0)
                    begin
                        if (free_bytes >= BUF_BYTES)
                            r.status = ST_DONE;
                        else
                        begin
                            sz = head_size();
                            if (used + sz >= budget)
                                r.status = ST_DONE;
                            else
                                frame_rem = sz;
                        end
                    end
                    if (r.status == ST_DONE)
                        draining = 0;
                    else
                    begin
                        r.obyte = ring[rd_idx];
                        rd_idx = (rd_idx + 1) % BUF_BYTES;
                        if (free_bytes < BUF_BYTES)
                            free_bytes++;
                        frame_rem--;
                        used = (used + 1) & 16'hFFFF;
                        r.status = ST_BYTE;
                    end
                end
            end
        endcase
        r.total = used[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        results_seen = 0;
        drops_seen = 0;
        rejects_seen = 0;
        wr_idx = 0;
        rd_idx = 0;
        free_bytes = BUF_BYTES;
        payload_left = 0;
        skipping = 0;
        budget = 0;
        used = 0;
        frame_rem = 0;
        draining = 0;
        foreach (ring[i])
            ring[i] = '0;
    end

    // Prediction on request, comparison on result
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(log_predict(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t result item with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.obyte)
                        report_mismatch("out_byte", m_axis_tdata[7:0], want.obyte);
                    if (m_axis_tdata[10:8] !== want.status)
                        report_mismatch("out_status", m_axis_tdata[10:8], want.status);
                    if (m_axis_tdata[26:11] !== want.total)
                        report_mismatch("drained_total", m_axis_tdata[26:11], want.total);
                    if (m_axis_tdata[31:27] !== 5'd0)
                        report_mismatch("fill bits", m_axis_tdata[31:27], 0);
                end
            end
            pending_count = expected_results.size();
        end
    end
endmodule

/* test/tb_message_ring_log_buffer_unit.sv */
`timescale 1ns / 100ps

module tb_message_ring_log_buffer_unit;
    import mrlb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          results_seen;
    int          drops_seen;
    int          rejects_seen;
    int          items_sent;
    bit          sink_hold;
    logic [2:0]  last_status;

    message_ring_log_buffer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mrlb_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .results_seen  (results_seen),
        .drops_seen    (drops_seen),
        .rejects_seen  (rejects_seen)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request item, with a random gap in front of it
    task automatic send_req(logic [1:0] req, logic [15:0] len, logic [31:0] stamp,
                            logic [7:0] dbyte, logic [15:0] limit, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        repeat (g)
            @(negedge clk);
        s_axis_tdata  <= {6'd0, limit, dbyte, stamp, len, req};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 80'({$urandom, $urandom, $urandom});
        items_sent++;
    endtask

    // Random request of any kind; a begin asks for a short message
    task automatic send_noise();
        send_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 20)), $urandom,
                 8'($urandom), 16'($urandom));
    endtask

    task automatic send_msg(logic [15:0] len, int extra_noise);
        send_req(REQ_BEGIN, len, $urandom, 8'($urandom), 16'($urandom));
        for (int i = 0; i < len; i++)
        begin
            send_req(REQ_DATA, 16'($urandom), $urandom, 8'($urandom), 16'($urandom));
            if (extra_noise > 0 && $urandom_range(0, 199) == 0)
                send_noise();
        end
    endtask

    task automatic drain(logic [15:0] limit, int max_fetch);
        send_req(REQ_OPEN, 16'($urandom), $urandom, 8'($urandom), limit);
        for (int i = 0; i < max_fetch; i++)
            send_req(REQ_FETCH, 16'($urandom), $urandom, 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Status of the last result taken
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            last_status <= m_axis_tdata[10:8];
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        int p;
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 70)
                m_axis_tready <= 1'b1;
            else if (p < 97)
                m_axis_tready <= 1'b0;
            else
            begin
                m_axis_tready <= 1'b0;
                sink_hold = 1;
                repeat ($urandom_range(10, 40))
                    @(negedge clk);
                sink_hold = 0;
            end
        end
    end

    initial
    begin
        int len;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        sink_hold     = 0;
        items_sent    = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: out-of-order requests on an idle block
        send_req(REQ_DATA, 16'h0, 32'h0, 8'hFF, 16'h0);
        send_req(REQ_FETCH, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF);
        // empty drain
        drain(16'hFFFF, 2);
        // zero-length message, then extremes of stamp and data
        send_req(REQ_BEGIN, 16'h0, 32'hFFFFFFFF, 8'h00, 16'h0);
        send_req(REQ_BEGIN, 16'd2, 32'h0, 8'h0, 16'h0);
        send_req(REQ_BEGIN, 16'd1, 32'h0, 8'h0, 16'h0); // begin while pending
        send_req(REQ_OPEN, 16'd0, 32'h0, 8'h0, 16'd50); // open while pending
        send_req(REQ_DATA, 16'h0, 32'h0, 8'hFF, 16'h0);
        send_req(REQ_DATA, 16'h0, 32'h0, 8'h00, 16'h0);
        // sender holds off until everything has come back
        wait_drained();
        // drain with limit equal to the first message, then just above it
        drain(16'd6, 2);
        drain(16'd7, 8);
        send_req(REQ_OPEN, 16'h0, 32'h0, 8'h0, 16'h0);
        send_req(REQ_BEGIN, 16'h0, 32'h0, 8'h0, 16'h0); // begin while draining
        drain(16'hFFFF, 16);
        // fill past capacity so the oldest messages are dropped, then a
        // longer message that drops many at once
        for (int i = 0; i < 700; i++)
            send_msg(($urandom_range(0, 9) == 0) ? 16'd1 : 16'd0, 0);
        send_msg(16'd200, 0);
        wait_drained();

        // Random: mostly well-formed traffic with random content
        while (items_sent < 1950)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 12);
                    send_msg(16'(len), 1);
                end
                5, 6:
                    drain(16'($urandom_range(0, 60)), $urandom_range(0, 40));
                7:
                    drain(16'($urandom_range(0, 300)), $urandom_range(0, 40));
                8:
                    send_noise();
                default:
                    send_req(REQ_FETCH, 16'($urandom), $urandom, 8'($urandom),
                             16'($urandom));
            endcase
        end

        // close any drain left open
        do
        begin
            send_req(REQ_FETCH, 16'h0, 32'h0, 8'h0, 16'h0);
            wait_drained();
        end
        while (last_status == ST_BYTE);

        // oversized message left pending to the end: its bytes are skipped
        // and other requests are refused
        send_req(REQ_BEGIN, 16'd4090, 32'h12345678, 8'h0, 16'h0);
        for (int i = 0; i < 3; i++)
            send_req(REQ_DATA, 16'h0, 32'h0, 8'($urandom), 16'h0, 1);
        send_req(REQ_BEGIN, 16'hFFFF, 32'h0, 8'h0, 16'h0);
        send_req(REQ_OPEN, 16'h0, 32'h0, 8'h0, 16'h0);
        send_req(REQ_FETCH, 16'h0, 32'h0, 8'h0, 16'h0);
        send_req(REQ_DATA, 16'h0, 32'h0, 8'hFF, 16'h0);

        wait_drained();
        repeat (100)
            @(negedge clk);
        $display("covered %0d request items, %0d results, %0d messages dropped for space,",
                 items_sent, results_seen, drops_seen);
        $display("%0d oversized messages rejected, with random stalls on both streams",
                 rejects_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_message_ring_log_buffer_unit passed");
        else
            $display("tb_message_ring_log_buffer_unit failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400ms;
        $display("tb_message_ring_log_buffer_unit failed");
        $finish;
    end
endmodule
